/* rtl/core/lppa_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Leased page pool allocator package
// Shared widths, default sizes, codes and the queued request word.
// ---------------------------------------------------------------------------
package lppa_pkg;

  // Default sizes of the pool.
  localparam int unsigned NumPagesDef    = 256;
  localparam int unsigned PageShiftDef   = 16;
  localparam int unsigned NumCoresDef    = 4;
  localparam int unsigned MaxMsgPagesDef = 16;
  localparam int unsigned MinExtra       = 4;

  // Fixed field widths.
  localparam int unsigned MsgLenW  = 21;
  localparam int unsigned CoreW    = 2;
  localparam int unsigned NowW     = 64;
  localparam int unsigned RelOffW  = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned BufOffW  = 24;
  localparam int unsigned FreeW    = 9;
  localparam int unsigned PiuW     = 9;
  localparam int unsigned LeaseW   = 32;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned RefsW    = 16;

  // Result status codes.
  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusNoSpace = 2'd1;
  localparam logic [StatusW-1:0] StatusBadIdx  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgPagesInUse = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgLeaseTime  = 1'b1;

  // Request codes.
  localparam logic ActAlloc   = 1'b0;
  localparam logic ActRelease = 1'b1;

  // A classified request word as it waits in the queue.
  typedef struct packed {
    logic               action;
    logic               too_big;
    logic               has_tail;
    logic               group_end;
    logic [CoreW-1:0]   core;
    logic [MsgLenW-1:0] full_pages;
    logic [MsgLenW-1:0] part_bytes;
    logic [NowW-1:0]    now;
    logic [RelOffW-1:0] rel_offset;
  } req_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic valid;
    req_t req;
  } head_t;

endpackage

/* rtl/core/leased_page_pool_allocator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Leased page pool allocator
// Reference-counted page pool with per-core leased tail pages.
// ---------------------------------------------------------------------------
// Usage:
// The request channel (in_valid_i / in_stall_o) carries one word per
// allocation or release. A two-entry queue decouples it from the sequencer,
// so up to two words are taken while an earlier one is still at work.
// The result channel (out_valid_o / out_stall_i) returns one word per
// buffer of an allocation, in message order, with last_o on the final one;
// a release, an empty message or a failure gives a single word.
// Sequence: a release reads and updates one descriptor before its result. An
// allocation scans descriptors, recalculating the scan limit as it wraps,
// checks the tail-page hint, rolls back taken pages on failure, then emits
// its result words. The single descriptor memory port paces these steps.
// Reset clears every descriptor at once through per-page valid bits; there
// is no clearing pass. A write to pages_in_use does the same.
// A stalled receiver holds the result register and the sequencer waits.
// ---------------------------------------------------------------------------
module leased_page_pool_allocator #(
  parameter int unsigned NumPages    = lppa_pkg::NumPagesDef,
  parameter int unsigned PageShift   = lppa_pkg::PageShiftDef,
  parameter int unsigned NumCores    = lppa_pkg::NumCoresDef,
  parameter int unsigned MaxMsgPages = lppa_pkg::MaxMsgPagesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lppa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lppa_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           action_i,
  input  logic [lppa_pkg::MsgLenW-1:0]   msg_length_i,
  input  logic [lppa_pkg::CoreW-1:0]     core_i,
  input  logic [lppa_pkg::NowW-1:0]      now_i,
  input  logic [lppa_pkg::RelOffW-1:0]   release_offset_i,
  input  logic                           group_end_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lppa_pkg::StatusW-1:0]   status_o,
  output logic                           offset_valid_o,
  output logic [lppa_pkg::BufOffW-1:0]   buffer_offset_o,
  output logic                           last_o,
  output logic [lppa_pkg::FreeW-1:0]     free_pages_o
);
  import lppa_pkg::*;

  head_t head;
  logic  pop;

  lppa_front #(
    .PageShift   (PageShift),
    .NumCores    (NumCores),
    .MaxMsgPages (MaxMsgPages)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .msg_length_i     (msg_length_i),
    .core_i           (core_i),
    .now_i            (now_i),
    .release_offset_i (release_offset_i),
    .group_end_i      (group_end_i),
    .head_o           (head),
    .pop_i            (pop)
  );

  lppa_back #(
    .NumPages    (NumPages),
    .PageShift   (PageShift),
    .NumCores    (NumCores),
    .MaxMsgPages (MaxMsgPages)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .offset_valid_o  (offset_valid_o),
    .buffer_offset_o (buffer_offset_o),
    .last_o          (last_o),
    .free_pages_o    (free_pages_o)
  );

endmodule

/* rtl/core/lppa_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module lppa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(Depth)-1:0]       waddr_i,
  input  logic [Width-1:0]               wdata_i,
  input  logic [$clog2(Depth)-1:0]       raddr_i,
  output logic [Width-1:0]               rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/lppa_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Request front end
// Accepts request words, splits the length into pages and queues them.
// ---------------------------------------------------------------------------
module lppa_front #(
  parameter int unsigned PageShift   = lppa_pkg::PageShiftDef,
  parameter int unsigned NumCores    = lppa_pkg::NumCoresDef,
  parameter int unsigned MaxMsgPages = lppa_pkg::MaxMsgPagesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [lppa_pkg::MsgLenW-1:0]  msg_length_i,
  input  logic [lppa_pkg::CoreW-1:0]    core_i,
  input  logic [lppa_pkg::NowW-1:0]     now_i,
  input  logic [lppa_pkg::RelOffW-1:0]  release_offset_i,
  input  logic                          group_end_i,
  output lppa_pkg::head_t               head_o,
  input  logic                          pop_i
);
  import lppa_pkg::*;

  localparam logic [MsgLenW-1:0] PartMask = MsgLenW'((64'd1 << PageShift) - 64'd1);
  localparam logic [MsgLenW:0]   MaxNeed  = (MsgLenW + 1)'(MaxMsgPages);
  localparam logic [CoreW:0]     NumCoresC = (CoreW + 1)'(NumCores > 7 ? 7 : NumCores);

  req_t        req;
  req_t        q_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  logic [CoreW:0] core_mod;

  // Core index modulo the core count, at most three subtractions.
  always_comb begin
    core_mod = {1'b0, core_i};
    for (int k = 0; k < 3; k++) begin
      if (core_mod >= NumCoresC) begin
        core_mod = core_mod - NumCoresC;
      end
    end
  end

  // Classify the incoming word.
  always_comb begin
    req            = '0;
    req.action     = action_i;
    req.group_end  = group_end_i;
    req.core       = core_mod[CoreW-1:0];
    req.now        = now_i;
    req.rel_offset = release_offset_i;
    req.full_pages = msg_length_i >> PageShift;
    req.part_bytes = msg_length_i & PartMask;
    req.has_tail   = (req.part_bytes != '0);
    req.too_big    = ({1'b0, req.full_pages} + (MsgLenW + 1)'(req.has_tail)) > MaxNeed;
  end

  // Two-entry queue between front and back.
  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o;
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.req   = q_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    cnt_d = cnt_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_ptr_q] <= req;
    end
  end

endmodule

/* rtl/core/lppa_back.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Allocation back end
// Sequencer over the page descriptors: scans, leases, rolls back, releases
// and delivers the result words.
// ---------------------------------------------------------------------------
module lppa_back #(
  parameter int unsigned NumPages    = lppa_pkg::NumPagesDef,
  parameter int unsigned PageShift   = lppa_pkg::PageShiftDef,
  parameter int unsigned NumCores    = lppa_pkg::NumCoresDef,
  parameter int unsigned MaxMsgPages = lppa_pkg::MaxMsgPagesDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lppa_pkg::head_t                head_i,
  output logic                           pop_o,
  input  logic                           cfg_we_i,
  input  logic [lppa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lppa_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lppa_pkg::StatusW-1:0]   status_o,
  output logic                           offset_valid_o,
  output logic [lppa_pkg::BufOffW-1:0]   buffer_offset_o,
  output logic                           last_o,
  output logic [lppa_pkg::FreeW-1:0]     free_pages_o
);
  import lppa_pkg::*;

  localparam int unsigned AW   = (NumPages > 1) ? $clog2(NumPages) : 1;
  localparam int unsigned FCW  = $clog2(NumPages + 1);
  localparam int unsigned CIW  = (NumCores > 1) ? $clog2(NumCores) : 1;
  localparam int unsigned CNTW = $clog2(MaxMsgPages + 1);
  localparam int unsigned LW   = (MaxMsgPages > 1) ? $clog2(MaxMsgPages) : 1;
  localparam int unsigned HUW  = PageShift + 1;
  localparam int unsigned TOW  = AW + PageShift + 1;
  localparam int unsigned IDXW = RelOffW - PageShift;
  localparam int unsigned DW   = RefsW + 1 + CIW + NowW;
  localparam int unsigned CMPW = (IDXW > FCW) ? IDXW : FCW;
  localparam logic [RefsW-1:0] RefsMax = '1;
  localparam logic [HUW:0]     PageBytes = (HUW + 1)'(64'd1 << PageShift);
  localparam logic [FCW:0]     MinExtraC = (FCW + 1)'(MinExtra);
  localparam logic [FCW:0]     NumPagesC = (FCW + 1)'(NumPages);

  typedef enum logic [9:0] {
    StIdle    = 10'b0000000001,
    StScan    = 10'b0000000010,
    StScanChk = 10'b0000000100,
    StHintRd  = 10'b0000001000,
    StHintChk = 10'b0000010000,
    StLease   = 10'b0000100000,
    StRollRd  = 10'b0001000000,
    StRollChk = 10'b0010000000,
    StRelChk  = 10'b0100000000,
    StEmit    = 10'b1000000000
  } state_e;

  state_e             state_q, state_d;
  logic [FCW-1:0]     piu_q, piu_d;
  logic [LeaseW-1:0]  lease_q, lease_d;
  logic [FCW-1:0]     free_q, free_d;
  logic [NumPages-1:0] vld_q, vld_d;
  logic [FCW-1:0]     scan_q [NumCores];
  logic [FCW-1:0]     scan_d [NumCores];
  logic [AW-1:0]      hpage_q [NumCores];
  logic [AW-1:0]      hpage_d [NumCores];
  logic [HUW-1:0]     hused_q [NumCores];
  logic [HUW-1:0]     hused_d [NumCores];
  logic               gbad_q, gbad_d;
  logic [CIW-1:0]     c_q, c_d;
  logic [NowW-1:0]    now_q, now_d;
  logic [CNTW-1:0]    full_q, full_d;
  logic [PageShift-1:0] part_q, part_d;
  logic               tail_q, tail_d;
  logic               gend_q, gend_d;
  logic               owned_q, owned_d;
  logic [CNTW-1:0]    target_q, target_d;
  logic [CNTW-1:0]    got_q, got_d;
  logic [CNTW-1:0]    nres_q, nres_d;
  logic [CNTW-1:0]    eidx_q, eidx_d;
  logic [AW-1:0]      cur_q, cur_d;
  logic [FCW-1:0]     limit_q, limit_d;
  logic               lim_ok_q, lim_ok_d;
  logic [AW-1:0]      list_q [MaxMsgPages];
  logic [AW-1:0]      list_d [MaxMsgPages];
  logic [BufOffW-1:0] tail_off_q, tail_off_d;
  logic               single_q, single_d;
  logic [StatusW-1:0] sstat_q, sstat_d;
  logic               ov_q, ov_d;
  logic [StatusW-1:0] ostat_q, ostat_d;
  logic               ooffv_q, ooffv_d;
  logic [BufOffW-1:0] ooff_q, ooff_d;
  logic               olast_q, olast_d;
  logic [FCW-1:0]     ofree_q, ofree_d;

  // Descriptor memory port.
  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [DW-1:0]      ram_wdata;
  logic [DW-1:0]      ram_rdata;
  logic [DW-1:0]      desc;
  logic [RefsW-1:0]   d_refs;
  logic               d_ownv;
  logic [CIW-1:0]     d_own;
  logic [NowW-1:0]    d_exp;
  logic               slot_free;

  // Scan helpers.
  logic [FCW-1:0]     used;
  logic [FCW:0]       extra, lim_w;
  logic [FCW-1:0]     cur_scan;
  logic               avail;
  logic [NowW-1:0]    new_exp;
  logic [CMPW-1:0]    rel_idx;
  logic [HUW:0]       hsum;
  logic               overflow, keep;
  logic [HUW-1:0]     hu_new;
  logic [PiuW-1:0]    cfg_piu;

  lppa_ram #(.Width(DW), .Depth(2 ** AW)) u_desc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A descriptor never written since the last reinit reads as cleared.
  assign desc   = vld_q[cur_q] ? ram_rdata : {{RefsW{1'b0}}, 1'b0, {CIW{1'b0}}, {NowW{1'b0}}};
  assign d_refs = desc[DW-1 -: RefsW];
  assign d_ownv = desc[NowW + CIW];
  assign d_own  = desc[NowW +: CIW];
  assign d_exp  = desc[NowW-1:0];

  assign slot_free = !ov_q || !out_stall_i;
  assign new_exp   = now_q + NowW'(lease_q);
  assign avail     = (d_refs == '0) || ((d_refs == RefsW'(1)) && d_ownv && (d_exp <= now_q));
  assign rel_idx   = CMPW'(head_i.req.rel_offset >> PageShift);
  assign cur_scan  = scan_q[c_q];
  assign hsum      = (HUW + 1)'(hused_q[c_q]) + (HUW + 1)'(part_q);
  assign overflow  = hsum > PageBytes;
  assign keep      = d_ownv && (d_own == c_q) && (d_refs != '0);
  assign cfg_piu   = cfg_data_i[PiuW-1:0];

  // Scan bound from the number of pages in use.
  always_comb begin
    used  = (free_q > piu_q) ? '0 : piu_q - free_q;
    extra = (FCW + 1)'(used >> 2);
    if (extra < MinExtraC) begin
      extra = MinExtraC;
    end
    lim_w = (FCW + 1)'(used) + extra;
    if (lim_w > (FCW + 1)'(piu_q)) begin
      lim_w = (FCW + 1)'(piu_q);
    end
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    piu_d      = piu_q;
    lease_d    = lease_q;
    free_d     = free_q;
    vld_d      = vld_q;
    scan_d     = scan_q;
    hpage_d    = hpage_q;
    hused_d    = hused_q;
    gbad_d     = gbad_q;
    c_d        = c_q;
    now_d      = now_q;
    full_d     = full_q;
    part_d     = part_q;
    tail_d     = tail_q;
    gend_d     = gend_q;
    owned_d    = owned_q;
    target_d   = target_q;
    got_d      = got_q;
    nres_d     = nres_q;
    eidx_d     = eidx_q;
    cur_d      = cur_q;
    limit_d    = limit_q;
    lim_ok_d   = lim_ok_q;
    list_d     = list_q;
    tail_off_d = tail_off_q;
    single_d   = single_q;
    sstat_d    = sstat_q;
    ov_d       = ov_q && out_stall_i;
    ostat_d    = ostat_q;
    ooffv_d    = ooffv_q;
    ooff_d     = ooff_q;
    olast_d    = olast_q;
    ofree_d    = ofree_q;
    pop_o      = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = cur_q;
    ram_wdata  = {d_refs, d_ownv, d_own, d_exp};

    case (state_q)
      StIdle: begin
        if (head_i.valid) begin
          pop_o    = 1'b1;
          c_d      = CIW'(head_i.req.core);
          now_d    = head_i.req.now;
          gend_d   = head_i.req.group_end;
          full_d   = CNTW'(head_i.req.full_pages);
          part_d   = PageShift'(head_i.req.part_bytes);
          tail_d   = head_i.req.has_tail;
          nres_d   = CNTW'(head_i.req.full_pages) + CNTW'(head_i.req.has_tail);
          eidx_d   = '0;
          got_d    = '0;
          single_d = 1'b1;
          sstat_d  = StatusOk;
          state_d  = StEmit;
          if (head_i.req.action == ActRelease) begin
            if (rel_idx < CMPW'(piu_q)) begin
              cur_d     = AW'(rel_idx);
              ram_raddr = AW'(rel_idx);
              state_d   = StRelChk;
            end else begin
              sstat_d = StatusBadIdx;
              gbad_d  = !head_i.req.group_end;
            end
          end else if (head_i.req.too_big) begin
            sstat_d = StatusNoSpace;
          end else if (head_i.req.full_pages != '0) begin
            if (free_q < FCW'(head_i.req.full_pages)) begin
              sstat_d = StatusNoSpace;
            end else begin
              free_d   = free_q - FCW'(head_i.req.full_pages);
              target_d = CNTW'(head_i.req.full_pages);
              owned_d  = 1'b0;
              lim_ok_d = 1'b0;
              single_d = 1'b0;
              state_d  = StScan;
            end
          end else if (head_i.req.has_tail) begin
            single_d = 1'b0;
            state_d  = StHintRd;
          end
        end
      end

      StScan: begin
        if (!lim_ok_q) begin
          limit_d  = FCW'(lim_w);
          lim_ok_d = 1'b1;
        end else if (cur_scan >= limit_q) begin
          scan_d[c_q] = '0;
          lim_ok_d    = 1'b0;
        end else begin
          scan_d[c_q] = cur_scan + FCW'(1);
          cur_d       = AW'(cur_scan);
          ram_raddr   = AW'(cur_scan);
          state_d     = StScanChk;
        end
      end

      StScanChk: begin
        if (!avail) begin
          state_d = StScan;
        end else begin
          if (d_ownv && (d_refs == RefsW'(1))) begin
            free_d = free_d + FCW'(1);
          end
          ram_we = 1'b1;
          vld_d[cur_q] = 1'b1;
          ram_wdata = {owned_q ? RefsW'(2) : RefsW'(1), owned_q,
                       owned_q ? c_q : CIW'(0), new_exp};
          if (owned_q) begin
            hpage_d[c_q] = cur_q;
            hused_d[c_q] = HUW'(part_q);
            tail_off_d   = BufOffW'(TOW'(cur_q) << PageShift);
            state_d      = StEmit;
          end else begin
            list_d[got_q[LW-1:0]] = cur_q;
            got_d = got_q + CNTW'(1);
            if (got_q + CNTW'(1) == target_q) begin
              state_d = tail_q ? StHintRd : StEmit;
            end else begin
              state_d = StScan;
            end
          end
        end
      end

      StHintRd: begin
        if (FCW'(hpage_q[c_q]) < piu_q) begin
          cur_d     = hpage_q[c_q];
          ram_raddr = hpage_q[c_q];
          state_d   = StHintChk;
        end else begin
          state_d = StLease;
        end
      end

      StHintChk: begin
        if (!keep) begin
          state_d = StLease;
        end else if ((overflow && (d_refs != RefsW'(1))) || (d_refs == RefsMax)) begin
          // Busy or saturated hint page: drop ownership and lease a new one.
          ram_we    = 1'b1;
          ram_wdata = {d_refs - RefsW'(1), 1'b0, CIW'(0), d_exp};
          state_d   = StLease;
        end else begin
          hu_new       = overflow ? '0 : hused_q[c_q];
          ram_we       = 1'b1;
          ram_wdata    = {d_refs + RefsW'(1), d_ownv, d_own, new_exp};
          tail_off_d   = BufOffW'((TOW'(cur_q) << PageShift) + TOW'(hu_new));
          hused_d[c_q] = hu_new + HUW'(part_q);
          state_d      = StEmit;
        end
      end

      StLease: begin
        if (free_q == '0) begin
          single_d = 1'b1;
          sstat_d  = StatusNoSpace;
          eidx_d   = '0;
          state_d  = (full_q != '0) ? StRollRd : StEmit;
        end else begin
          free_d   = free_q - FCW'(1);
          target_d = CNTW'(1);
          got_d    = '0;
          owned_d  = 1'b1;
          lim_ok_d = 1'b0;
          state_d  = StScan;
        end
      end

      // Rollback walks the taken pages with the emit index.
      StRollRd: begin
        cur_d     = list_q[eidx_q[LW-1:0]];
        ram_raddr = list_q[eidx_q[LW-1:0]];
        state_d   = StRollChk;
      end

      StRollChk: begin
        if (d_refs != '0) begin
          ram_we    = 1'b1;
          ram_wdata = {d_refs - RefsW'(1), d_ownv, d_own, d_exp};
          if (d_refs == RefsW'(1)) begin
            free_d = free_q + FCW'(1);
          end
        end
        eidx_d = eidx_q + CNTW'(1);
        if (eidx_q + CNTW'(1) == full_q) begin
          eidx_d  = '0;
          state_d = StEmit;
        end else begin
          state_d = StRollRd;
        end
      end

      StRelChk: begin
        if (d_refs != '0) begin
          ram_we    = 1'b1;
          ram_wdata = {d_refs - RefsW'(1), d_ownv, d_own, d_exp};
          if (d_refs == RefsW'(1)) begin
            free_d = free_q + FCW'(1);
          end
        end
        sstat_d = gbad_q ? StatusBadIdx : StatusOk;
        if (gend_q) begin
          gbad_d = 1'b0;
        end
        state_d = StEmit;
      end

      StEmit: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          ofree_d = free_q;
          if (single_q) begin
            ostat_d = sstat_q;
            ooffv_d = 1'b0;
            ooff_d  = '0;
            olast_d = 1'b1;
            state_d = StIdle;
          end else begin
            ostat_d = StatusOk;
            ooffv_d = 1'b1;
            ooff_d  = (eidx_q < full_q) ?
                      BufOffW'(TOW'(list_q[eidx_q[LW-1:0]]) << PageShift) : tail_off_q;
            olast_d = (eidx_q + CNTW'(1) == nres_q);
            eidx_d  = eidx_q + CNTW'(1);
            if (eidx_q + CNTW'(1) == nres_q) begin
              state_d = StIdle;
            end
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // Configuration writes must arrive only while the sequencer is idle; the block itself does not enforce it.
    if (cfg_we_i) begin
      if (cfg_index_i == CfgPagesInUse) begin
        if (cfg_piu < PiuW'(2)) begin
          piu_d = FCW'(2);
        end else if ((FCW + 1)'(cfg_piu) > NumPagesC) begin
          piu_d = FCW'(NumPages);
        end else begin
          piu_d = FCW'(cfg_piu);
        end
        free_d = piu_d;
        vld_d  = '0;
        gbad_d = 1'b0;
        for (int k = 0; k < NumCores; k++) begin
          scan_d[k]  = '0;
          hpage_d[k] = '0;
          hused_d[k] = '0;
        end
      end else if (cfg_index_i == CfgLeaseTime) begin
        lease_d = cfg_data_i[LeaseW-1:0];
      end
    end
  end

  // Control and pool state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      piu_q    <= FCW'(NumPages);
      lease_q  <= '0;
      free_q   <= FCW'(NumPages);
      vld_q    <= '0;
      gbad_q   <= 1'b0;
      ov_q     <= 1'b0;
      lim_ok_q <= 1'b0;
      for (int k = 0; k < NumCores; k++) begin
        scan_q[k]  <= '0;
        hpage_q[k] <= '0;
        hused_q[k] <= '0;
      end
    end else begin
      state_q  <= state_d;
      piu_q    <= piu_d;
      lease_q  <= lease_d;
      free_q   <= free_d;
      vld_q    <= vld_d;
      gbad_q   <= gbad_d;
      ov_q     <= ov_d;
      lim_ok_q <= lim_ok_d;
      scan_q   <= scan_d;
      hpage_q  <= hpage_d;
      hused_q  <= hused_d;
    end
  end

  // Working and result payload.
  always_ff @(posedge clk_i) begin
    c_q        <= c_d;
    now_q      <= now_d;
    full_q     <= full_d;
    part_q     <= part_d;
    tail_q     <= tail_d;
    gend_q     <= gend_d;
    owned_q    <= owned_d;
    target_q   <= target_d;
    got_q      <= got_d;
    nres_q     <= nres_d;
    eidx_q     <= eidx_d;
    cur_q      <= cur_d;
    limit_q    <= limit_d;
    list_q     <= list_d;
    tail_off_q <= tail_off_d;
    single_q   <= single_d;
    sstat_q    <= sstat_d;
    ostat_q    <= ostat_d;
    ooffv_q    <= ooffv_d;
    ooff_q     <= ooff_d;
    olast_q    <= olast_d;
    ofree_q    <= ofree_d;
  end

  assign out_valid_o     = ov_q;
  assign status_o        = ostat_q;
  assign offset_valid_o  = ooffv_q;
  assign buffer_offset_o = ooff_q;
  assign last_o          = olast_q;
  assign free_pages_o    = FreeW'(ofree_q);

endmodule

/* dv/leased_page_pool_allocator_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Leased page pool allocator checker
// Watches the request, result and configuration ports of the allocator. It
// keeps its own copy of the page descriptors, predicts the result words of
// every accepted request word, and compares them in order with the words
// that the block returns.
// ---------------------------------------------------------------------------
module leased_page_pool_allocator_checker
  import lppa_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                action_i,
  input  logic [MsgLenW-1:0]  msg_length_i,
  input  logic [CoreW-1:0]    core_i,
  input  logic [NowW-1:0]     now_i,
  input  logic [RelOffW-1:0]  release_offset_i,
  input  logic                group_end_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [StatusW-1:0]  status_i,
  input  logic                offset_valid_i,
  input  logic [BufOffW-1:0]  buffer_offset_i,
  input  logic                last_i,
  input  logic [FreeW-1:0]    free_pages_i,
  output int                  errors_o,
  output int                  pending_o
);

  localparam int unsigned Pages    = NumPagesDef;
  localparam int unsigned Cores    = NumCoresDef;
  localparam int unsigned MaxPages = MaxMsgPagesDef;
  localparam logic [2:0]  NoCore   = 3'd7;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               offset_valid;
    logic [BufOffW-1:0] buffer_offset;
    logic               last;
    logic [FreeW-1:0]   free_pages;
  } result_word_t;

  // Shadow copy of the pool.
  logic [RefsW-1:0]  refs    [Pages];
  logic [2:0]        owner   [Pages];
  logic [NowW-1:0]   expiry  [Pages];
  logic [FreeW-1:0]  free_cnt;
  logic [8:0]        scan_pos [Cores];
  logic [7:0]        hint_pg  [Cores];
  logic [16:0]       hint_fill[Cores];
  logic [PiuW-1:0]   pool_size;
  logic [LeaseW-1:0] lease;
  logic              group_bad;
  int unsigned       taken[MaxPages + 1];

  result_word_t expected_words[$];

  assign pending_o = expected_words.size();

  // Clears all descriptors, as a reset or a pool size write does.
  function automatic void clear_pool();
    for (int i = 0; i < Pages; i++) begin
      refs[i] = '0;
      owner[i] = NoCore;
      expiry[i] = '0;
    end
    for (int i = 0; i < Cores; i++) begin
      scan_pos[i] = '0;
      hint_pg[i] = '0;
      hint_fill[i] = '0;
    end
    free_cnt = pool_size;
    group_bad = 1'b0;
  endfunction

  function automatic bit page_free(int unsigned p, logic [NowW-1:0] now);
    return refs[p] == 0 || (refs[p] == 1 && owner[p] != NoCore && expiry[p] <= now);
  endfunction

  function automatic void drop_page(int unsigned p);
    if (refs[p] != 0) begin
      refs[p] = refs[p] - 1'b1;
      if (refs[p] == 0) free_cnt = free_cnt + 1'b1;
    end
  endfunction

  // Rotating scan for n pages; the chosen indexes land in taken[].
  function automatic bit take_pages(int unsigned n, int unsigned c, logic [NowW-1:0] now,
                                    bit owned);
    int unsigned got, limit, used, extra, cur;
    got = 0;
    limit = 0;
    if (free_cnt < n) return 1'b0;
    free_cnt = free_cnt - n;
    while (got != n) begin
      if (limit == 0) begin
        used = (free_cnt > pool_size) ? 0 : pool_size - free_cnt;
        extra = used >> 2;
        limit = used + ((extra < MinExtra) ? MinExtra : extra);
        if (limit > pool_size) limit = pool_size;
      end
      cur = scan_pos[c];
      scan_pos[c] = cur + 1;
      if (cur >= limit) begin
        scan_pos[c] = '0;
        limit = 0;
        continue;
      end
      if (!page_free(cur, now)) continue;
      // A stolen page with its single owner reference was not counted as free.
      if (owner[cur] != NoCore && refs[cur] == 1) free_cnt = free_cnt + 1'b1;
      refs[cur] = owned ? 16'd2 : 16'd1;
      owner[cur] = owned ? 3'(c) : NoCore;
      expiry[cur] = now + NowW'(lease);
      taken[got] = cur;
      got++;
    end
    return 1'b1;
  endfunction

  function automatic void push_word(logic [StatusW-1:0] st, logic ov, logic [BufOffW-1:0] off,
                                    logic lst);
    result_word_t w;
    w.status = st;
    w.offset_valid = ov;
    w.buffer_offset = off;
    w.last = lst;
    w.free_pages = free_cnt;
    expected_words.push_back(w);
  endfunction

  // Works out the result words of one allocation request.
  function automatic void predict_alloc(logic [MsgLenW-1:0] len, int unsigned c,
                                        logic [NowW-1:0] now);
    int unsigned full, part, need, n, hp;
    int unsigned full_list[MaxPages + 1];
    logic [BufOffW-1:0] offs[MaxPages + 1];
    bit keep, overflow;
    full = len >> PageShiftDef;
    part = len & ((1 << PageShiftDef) - 1);
    need = full + (part != 0);
    if (need > MaxPages) begin
      push_word(StatusNoSpace, 1'b0, '0, 1'b1);
      return;
    end
    if (full != 0 && !take_pages(full, c, now, 1'b0)) begin
      push_word(StatusNoSpace, 1'b0, '0, 1'b1);
      return;
    end
    for (int i = 0; i < full; i++) begin
      full_list[i] = taken[i];
      offs[i] = BufOffW'(taken[i] << PageShiftDef);
    end
    n = full;
    if (part != 0) begin
      hp = hint_pg[c];
      keep = hp < pool_size && owner[hp] == 3'(c) && refs[hp] != 0;
      if (keep) begin
        overflow = (hint_fill[c] + part) > (1 << PageShiftDef);
        if ((overflow && refs[hp] != 1) || refs[hp] == 16'hFFFF) begin
          // The busy hint page is abandoned to its remaining holders.
          owner[hp] = NoCore;
          refs[hp] = refs[hp] - 1'b1;
          keep = 1'b0;
        end else begin
          if (overflow) hint_fill[c] = '0;
          expiry[hp] = now + NowW'(lease);
          refs[hp] = refs[hp] + 1'b1;
        end
      end
      if (!keep) begin
        if (!take_pages(1, c, now, 1'b1)) begin
          for (int i = 0; i < full; i++) drop_page(full_list[i]);
          push_word(StatusNoSpace, 1'b0, '0, 1'b1);
          return;
        end
        hint_pg[c] = taken[0][7:0];
        hint_fill[c] = '0;
      end
      offs[n] = BufOffW'(hint_fill[c] + (int'(hint_pg[c]) << PageShiftDef));
      n++;
      hint_fill[c] = hint_fill[c] + part;
    end
    if (n == 0) begin
      push_word(StatusOk, 1'b0, '0, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++) push_word(StatusOk, 1'b1, offs[i], i + 1 == n);
  endfunction

  function automatic void predict_release(logic [RelOffW-1:0] off, logic grp);
    int unsigned idx;
    idx = off >> PageShiftDef;
    if (idx < pool_size) drop_page(idx);
    else group_bad = 1'b1;
    push_word(group_bad ? StatusBadIdx : StatusOk, 1'b0, '0, 1'b1);
    if (grp) group_bad = 1'b0;
  endfunction

  // Prediction and comparison, both at the rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    result_word_t w;
    if (!rst_ni) begin
      pool_size = PiuW'(Pages);
      lease = '0;
      clear_pool();
      expected_words.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgPagesInUse) begin
          if (cfg_data_i[8:0] < 2) pool_size = 9'd2;
          else if (cfg_data_i[8:0] > Pages) pool_size = PiuW'(Pages);
          else pool_size = cfg_data_i[8:0];
          clear_pool();
        end else if (cfg_index_i == CfgLeaseTime) begin
          lease = cfg_data_i;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (action_i == ActRelease) predict_release(release_offset_i, group_end_i);
        else predict_alloc(msg_length_i, int'(core_i) % Cores, now_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result word %h", $time,
                   {status_i, offset_valid_i, buffer_offset_i, last_i, free_pages_i});
        end else begin
          w = expected_words.pop_front();
          if (w.status !== status_i || w.offset_valid !== offset_valid_i ||
              w.buffer_offset !== buffer_offset_i || w.last !== last_i ||
              w.free_pages !== free_pages_i) begin
            errors_o++;
            $display("%0t: mismatch expected st=%0d ov=%0d off=%h last=%0d free=%0d",
                     $time, w.status, w.offset_valid, w.buffer_offset, w.last,
                     w.free_pages);
            $display("%0t:          actual   st=%0d ov=%0d off=%h last=%0d free=%0d",
                     $time, status_i, offset_valid_i, buffer_offset_i, last_i,
                     free_pages_i);
          end
        end
      end
    end
  end

endmodule

/* dv/leased_page_pool_allocator_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Leased page pool allocator testbench
// Drives allocation and release words at the allocator under several pool
// sizes and lease times, with random idling on both channels and one long
// hold-off of the result side. The checker predicts and compares every word.
// ---------------------------------------------------------------------------
module leased_page_pool_allocator_tb;
  import lppa_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                action_i = ActAlloc;
  logic [MsgLenW-1:0]  msg_length_i = '0;
  logic [CoreW-1:0]    core_i = '0;
  logic [NowW-1:0]     now_i = '0;
  logic [RelOffW-1:0]  release_offset_i = '0;
  logic                group_end_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic                offset_valid_o;
  logic [BufOffW-1:0]  buffer_offset_o;
  logic                last_o;
  logic [FreeW-1:0]    free_pages_o;

  int          errors;
  int          pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  logic [NowW-1:0]    clock_now = 64'd1000;
  logic [BufOffW-1:0] held_bufs[$];

  always #10 clk_i = ~clk_i;

  leased_page_pool_allocator uut (.*);

  leased_page_pool_allocator_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .action_i, .msg_length_i, .core_i, .now_i,
    .release_offset_i, .group_end_i, .out_valid_i(out_valid_o), .out_stall_i,
    .status_i(status_o), .offset_valid_i(offset_valid_o), .buffer_offset_i(buffer_offset_o),
    .last_i(last_o), .free_pages_i(free_pages_o), .errors_o(errors), .pending_o(pending)
  );

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_stall_i = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Buffers handed out are kept so that later words can release them.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i && offset_valid_o) held_bufs.push_back(buffer_offset_o);
  end

  // Offers one word and waits until it is taken.
  task automatic send_word(logic act, logic [MsgLenW-1:0] len, logic [CoreW-1:0] c,
                           logic [NowW-1:0] now, logic [RelOffW-1:0] off, logic grp);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    action_i = act;
    msg_length_i = len;
    core_i = c;
    now_i = now;
    release_offset_i = off;
    group_end_i = grp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic alloc_word(logic [MsgLenW-1:0] len, logic [CoreW-1:0] c, logic [NowW-1:0] now);
    send_word(ActAlloc, len, c, now, $urandom, $urandom_range(1));
  endtask

  task automatic release_word(logic [RelOffW-1:0] off, logic grp);
    send_word(ActRelease, MsgLenW'($urandom), CoreW'($urandom), clock_now, off, grp);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CfgPagesInUse) held_bufs.delete();
  endtask

  // One random word: mostly releases of held buffers and modest allocations.
  task automatic random_word();
    int unsigned r, k;
    logic [MsgLenW-1:0] len;
    r = $urandom_range(99);
    clock_now = clock_now + $urandom_range(300);
    if (r < 38 && held_bufs.size() != 0) begin
      k = $urandom_range(held_bufs.size() - 1);
      release_word(RelOffW'(held_bufs[k]) | ($urandom_range(1) ? 32'h0 : 32'h0000_1234),
                   $urandom_range(2) == 0);
      held_bufs.delete(k);
    end else if (r < 45) begin
      release_word($urandom_range(1) ? $urandom : ($urandom_range(300) << PageShiftDef),
                   $urandom_range(1));
    end else begin
      k = $urandom_range(99);
      if (k < 40) len = MsgLenW'($urandom_range(1, 65535));
      else if (k < 75) len = MsgLenW'(($urandom_range(3) << PageShiftDef) + $urandom_range(65535));
      else if (k < 85) len = MsgLenW'(($urandom_range(16) << PageShiftDef) + $urandom_range(1));
      else if (k < 92) len = MsgLenW'($urandom);
      else len = '0;
      alloc_word(len, CoreW'($urandom),
                 ($urandom_range(19) == 0) ? {$urandom, $urandom} : clock_now);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words on the default pool with no lease time.
    alloc_word('0, 2'd0, 64'd0);
    alloc_word(21'd1, 2'd0, 64'd10);
    alloc_word(21'd1, 2'd0, 64'd11);
    alloc_word(21'd65535, 2'd0, 64'd12);
    alloc_word(21'd65536, 2'd1, 64'd13);
    alloc_word(21'h1FFFFF, 2'd2, 64'd14);
    alloc_word(21'd1048576, 2'd3, 64'd15);
    alloc_word(21'd1048577, 2'd3, 64'd16);
    alloc_word(21'd200000, 2'd1, '1);
    release_word(32'hFFFF_FFFF, 1'b0);
    release_word(32'h0000_0000, 1'b1);
    release_word(32'h00FE_0000, 1'b1);
    release_word(32'h0100_0000, 1'b1);
    drain();
    repeat (6) begin
      if (held_bufs.size() != 0) release_word(RelOffW'(held_bufs.pop_front()), 1'b1);
    end
    alloc_word(21'd40000, 2'd0, 64'd100);
    alloc_word(21'd30000, 2'd2, 64'd101);
    drain();
    write_reg(CfgPagesInUse, 32'h0000_01FF);
    write_reg(CfgLeaseTime, 32'd100);

    // Sender rarely idles, receiver stalls often.
    send_idle_pct = 6;
    recv_idle_pct = 60;
    repeat (60) random_word();
    drain();
    write_reg(CfgPagesInUse, 32'h0000_0000);
    write_reg(CfgLeaseTime, 32'hFFFF_FFFF);

    // A tiny pool: failures, rollbacks and bad indexes.
    send_idle_pct = 60;
    recv_idle_pct = 6;
    repeat (60) random_word();
    drain();
    write_reg(CfgPagesInUse, 32'hFFFF_FE14);
    write_reg(CfgLeaseTime, 32'd50);

    // No idling; the result side first holds off for a long stretch.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    repeat (60) random_word();
    drain();
    repeat (50) @(posedge clk_i);

    if (errors == 0) begin
      $display("leased_page_pool_allocator_tb: PASS");
    end else begin
      $display("leased_page_pool_allocator_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("leased_page_pool_allocator_tb: FAIL");
    $finish;
  end

endmodule
